[rtl/drrip_pkg.sv]
// Shared types and constants for the DRRIP replacement engine.
// No dependencies. Used by the channel interfaces, the top level and the checker.
package drrip_pkg;

  localparam int unsigned SET_IDX_W = 11;
  localparam int unsigned WAY_IN_W  = 4;
  localparam int unsigned ADDR_W    = 20;
  localparam int unsigned STRIDE_W  = ADDR_W + 1;
  localparam int unsigned STREAK_W  = 8;
  localparam int unsigned CHANCE_W  = 5;
  localparam int unsigned SEL_OUT_W = 10;
  localparam int unsigned THR_W     = 8;

  localparam logic [THR_W-1:0] THR_RESET = 8'd4;

  localparam logic MODE_VICTIM = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;

  typedef struct packed {
    logic [STREAK_W-1:0] streak;
    logic [STRIDE_W-1:0] stride;
    logic [ADDR_W-1:0]   last_addr;
  } stream_entry_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

endpackage

[rtl/drrip_if.sv]
// Valid/ready channel interfaces for request and result transfers.
// Depends on drrip_pkg for field widths.
interface drrip_req_if;
  logic                               valid;
  logic                               ready;
  logic                               mode;
  logic [drrip_pkg::SET_IDX_W-1:0]    set_index;
  logic [drrip_pkg::WAY_IN_W-1:0]     way;
  logic [drrip_pkg::ADDR_W-1:0]       paddr_lo;
  logic                               hit;
  logic [drrip_pkg::CHANCE_W-1:0]     chance;

  modport source (output valid, mode, set_index, way, paddr_lo, hit, chance, input ready);
  modport sink   (input valid, mode, set_index, way, paddr_lo, hit, chance, output ready);
endinterface

interface drrip_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [drrip_pkg::WAY_IN_W-1:0]     victim_way;
  logic                               stream_seen;
  logic [drrip_pkg::SEL_OUT_W-1:0]    selector_value;

  modport source (output valid, victim_way, stream_seen, selector_value, input ready);
  modport sink   (input valid, victim_way, stream_seen, selector_value, output ready);
endinterface

[rtl/drrip_replacement_stream_bypass.sv]
// DRRIP replacement engine with per-set stride stream bypass.
// The result register loads in the cycle after the input transfer.
// A new item is taken only once the last one is done (set read, then modify and write back
// through the RRPV and stream RAMs); a stalled output holds the next transfer.
// Reset: a clearing pass writes all SET_COUNT sets with input ready low; the threshold
// register and selector reset at once.
module drrip_replacement_stream_bypass #(
  parameter int unsigned SET_COUNT      = 2048, // power of two
  parameter int unsigned WAY_COUNT      = 16,   // power of two
  parameter int unsigned LEADER_COUNT   = 64,
  parameter int unsigned SELECTOR_WIDTH = 10,
  parameter int unsigned RRPV_WIDTH     = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  drrip_req_if.sink                   req_i,
  drrip_rsp_if.source                 rsp_o,
  input  logic                        cfg_we_i,
  input  logic [drrip_pkg::THR_W-1:0] cfg_wdata_i
);

  localparam int unsigned AW      = $clog2(SET_COUNT);
  localparam int unsigned WW      = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int unsigned RW      = RRPV_WIDTH;
  localparam int unsigned SW      = SELECTOR_WIDTH;
  localparam int unsigned ROW_W   = WAY_COUNT * RW;
  localparam int unsigned GAP     = (SET_COUNT / LEADER_COUNT > 0) ?
                                    (SET_COUNT / LEADER_COUNT) : 1;
  localparam int unsigned GAP_W   = $clog2(GAP);
  localparam int unsigned ST_W    = $bits(drrip_pkg::stream_entry_t);
  localparam logic [RW-1:0] RRPV_TOP = '1;
  localparam logic [SW-1:0] SEL_TOP  = '1;
  localparam logic [SW-1:0] SEL_MID  = SW'((2 ** SW - 1) / 2);

  drrip_pkg::state_e state_q, state_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [drrip_pkg::THR_W-1:0] thr_q;
  logic [SW-1:0]     sel_q, sel_d;

  // captured item
  logic                          mode_q;
  logic [AW-1:0]                 set_q;
  logic [WW-1:0]                 way_q;
  logic [drrip_pkg::ADDR_W-1:0]  addr_q;
  logic                          hit_q;
  logic [drrip_pkg::CHANCE_W-1:0] chance_q;

  // output register
  logic                            out_valid_q, out_valid_d;
  logic [drrip_pkg::WAY_IN_W-1:0]  victim_q;
  logic                            seen_q;
  logic [drrip_pkg::SEL_OUT_W-1:0] selv_q;

  logic              accept, exec;
  logic [AW-1:0]     req_set;
  logic              rrpv_we, strm_we;
  logic [AW-1:0]     waddr;
  logic [ROW_W-1:0]  rrpv_wdata, rrpv_rdata, row_new;
  logic [ST_W-1:0]   strm_wdata, strm_rdata;
  drrip_pkg::stream_entry_t ent_rd, ent_new;

  logic [WW-1:0]                 victim_idx;
  logic                          seen;
  logic [RW-1:0]                 ins_val;
  logic                          leader, brrip_leader;

  assign req_set = AW'(32'(req_i.set_index));

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= drrip_pkg::ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      sel_q       <= SEL_MID;
      thr_q       <= drrip_pkg::THR_RESET;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      sel_q       <= sel_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    accept      = 1'b0;
    exec        = 1'b0;
    req_i.ready = 1'b0;
    case (state_q)
      drrip_pkg::ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(SET_COUNT - 1)) begin
          state_d = drrip_pkg::ST_IDLE;
        end
      end
      drrip_pkg::ST_IDLE: begin
        // output register is free by the time this item's result is ready
        req_i.ready = !out_valid_q || rsp_o.ready;
        accept      = req_i.valid && req_i.ready;
        if (accept) begin
          state_d = drrip_pkg::ST_EXEC;
        end
      end
      drrip_pkg::ST_EXEC: begin
        exec    = 1'b1;
        state_d = drrip_pkg::ST_IDLE;
      end
      default: begin
        state_d = drrip_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (exec) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q   <= req_i.mode;
      set_q    <= req_set;
      way_q    <= WW'(32'(req_i.way));
      addr_q   <= req_i.paddr_lo;
      hit_q    <= req_i.hit;
      chance_q <= req_i.chance;
    end
    if (exec) begin
      victim_q <= (mode_q == drrip_pkg::MODE_VICTIM) ?
                  drrip_pkg::WAY_IN_W'(victim_idx) : '0;
      seen_q   <= (mode_q == drrip_pkg::MODE_UPDATE) && seen;
      selv_q   <= drrip_pkg::SEL_OUT_W'(sel_d);
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.victim_way     = victim_q;
  assign rsp_o.stream_seen    = seen_q;
  assign rsp_o.selector_value = selv_q;

  // ---------------------------------------------------------------- memories
  drrip_ram #(.WIDTH(ROW_W), .DEPTH(SET_COUNT)) u_rrpv_ram (
    .clk_i   (clk_i),
    .we_i    (rrpv_we),
    .waddr_i (waddr),
    .wdata_i (rrpv_wdata),
    .raddr_i (req_set),
    .rdata_o (rrpv_rdata)
  );

  drrip_ram #(.WIDTH(ST_W), .DEPTH(SET_COUNT)) u_strm_ram (
    .clk_i   (clk_i),
    .we_i    (strm_we),
    .waddr_i (waddr),
    .wdata_i (strm_wdata),
    .raddr_i (req_set),
    .rdata_o (strm_rdata)
  );

  always_comb begin
    if (state_q == drrip_pkg::ST_CLEAR) begin
      waddr      = clr_q;
      rrpv_we    = 1'b1;
      strm_we    = 1'b1;
      rrpv_wdata = '1;
      strm_wdata = '0;
    end else begin
      waddr      = set_q;
      rrpv_we    = exec;
      strm_we    = exec && (mode_q == drrip_pkg::MODE_UPDATE);
      rrpv_wdata = row_new;
      strm_wdata = ST_W'(ent_new);
    end
  end

  // ---------------------------------------------------------------- victim / ageing
  always_comb begin
    logic [WAY_COUNT-1:0] cand;
    logic [WAY_COUNT-1:0] bitset;
    logic [RW-1:0]        top;
    logic [RW-1:0]        add;
    cand = '1;
    top  = '0;
    // max over ways, resolved one RRPV bit at a time from the MSB
    for (int b = RW - 1; b >= 0; b--) begin
      for (int w = 0; w < WAY_COUNT; w++) begin
        bitset[w] = cand[w] & rrpv_rdata[w*RW + b];
      end
      if (|bitset) begin
        top[b] = 1'b1;
        cand   = bitset;
      end
    end
    add = RRPV_TOP - top;
    // ways at the maximum become the top value after ageing; take the lowest
    victim_idx = '0;
    for (int w = WAY_COUNT - 1; w >= 0; w--) begin
      if (cand[w]) begin
        victim_idx = WW'(w);
      end
    end
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (mode_q == drrip_pkg::MODE_VICTIM) begin
        row_new[w*RW +: RW] = rrpv_rdata[w*RW +: RW] + add;
      end else if (way_q == WW'(w)) begin
        row_new[w*RW +: RW] = ins_val;
      end else begin
        row_new[w*RW +: RW] = rrpv_rdata[w*RW +: RW];
      end
    end
  end

  // ---------------------------------------------------------------- stream detector
  assign ent_rd = drrip_pkg::stream_entry_t'(strm_rdata);

  always_comb begin
    logic [drrip_pkg::STRIDE_W-1:0] d;
    d = {1'b0, addr_q} - {1'b0, ent_rd.last_addr};
    ent_new.last_addr = addr_q;
    seen              = 1'b0;
    if ((ent_rd.streak != '0) && (d == ent_rd.stride) && (d != '0)) begin
      ent_new.stride = ent_rd.stride;
      ent_new.streak = ent_rd.streak + drrip_pkg::STREAK_W'(1);
      seen           = (ent_new.streak >= thr_q);
    end else begin
      ent_new.stride = d;
      ent_new.streak = drrip_pkg::STREAK_W'(1);
    end
  end

  // ---------------------------------------------------------------- insertion and dueling
  always_comb begin
    logic [AW-1:0] lnum;
    logic [RW-1:0] bimodal;
    lnum         = set_q >> GAP_W;
    leader       = ((set_q & AW'(GAP - 1)) == '0) && (32'(lnum) < LEADER_COUNT);
    brrip_leader = 32'(lnum) >= (LEADER_COUNT / 2);
    bimodal      = (chance_q == '0) ? RW'(1) : RRPV_TOP;

    if (hit_q) begin
      ins_val = '0;
    end else if (seen) begin
      ins_val = RRPV_TOP;
    end else if (leader) begin
      ins_val = brrip_leader ? bimodal : RW'(1);
    end else begin
      ins_val = (sel_q >= SEL_MID) ? RW'(1) : bimodal;
    end

    sel_d = sel_q;
    if (exec && (mode_q == drrip_pkg::MODE_UPDATE) && !hit_q && leader) begin
      if (!brrip_leader) begin
        if (sel_q != '0) begin
          sel_d = sel_q - SW'(1);
        end
      end else if (sel_q != SEL_TOP) begin
        sel_d = sel_q + SW'(1);
      end
    end
  end

endmodule

[rtl/drrip_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module drrip_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/drrip_checker.sv]
// Port-level assertions for the DRRIP replacement engine, bound to the top level.
// Depends on drrip_pkg for field widths.
module drrip_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [drrip_pkg::WAY_IN_W-1:0]  victim_way_i,
  input logic                            stream_seen_i,
  input logic [drrip_pkg::SEL_OUT_W-1:0] selector_value_i
);

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_i;

  // one item in work at a time
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_xfer)
    else $error("input transfer on consecutive cycles");

  // result shows once the item has passed the execute state and the output register
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> ##2 out_valid_i)
    else $error("result missing after input transfer");

  // a victim result never reports streaming (checked where the victim way is nonzero)
  a_victim_no_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (victim_way_i != '0)) |-> !stream_seen_i)
    else $error("stream flag set on a victim result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(victim_way_i)
      && $stable(stream_seen_i) && $stable(selector_value_i)))
    else $error("stalled result changed");

endmodule

bind drrip_replacement_stream_bypass drrip_checker u_drrip_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (req_i.valid),
  .in_ready_i       (req_i.ready),
  .out_valid_i      (rsp_o.valid),
  .out_ready_i      (rsp_o.ready),
  .victim_way_i     (rsp_o.victim_way),
  .stream_seen_i    (rsp_o.stream_seen),
  .selector_value_i (rsp_o.selector_value)
);

[tb/drrip_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the DRRIP replacement engine: watches request, result and threshold
// traffic, predicts each result and compares it field by field. Depends on drrip_pkg
// and the channel interfaces in drrip_if.sv.
module drrip_scoreboard #(
  parameter int unsigned SET_COUNT      = 2048,
  parameter int unsigned WAY_COUNT      = 16,
  parameter int unsigned LEADER_COUNT   = 64,
  parameter int unsigned SELECTOR_WIDTH = 10,
  parameter int unsigned RRPV_WIDTH     = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [drrip_pkg::THR_W-1:0] cfg_wdata_i,
  drrip_req_if                        req_i,
  drrip_rsp_if                        rsp_i,
  output int unsigned                 errors_o,
  output int unsigned                 pending_o,
  output int unsigned                 checked_o,
  output int unsigned                 streams_o
);

  localparam int unsigned SET_IDX_W = drrip_pkg::SET_IDX_W;
  localparam int unsigned WAY_IN_W  = drrip_pkg::WAY_IN_W;
  localparam int unsigned ADDR_W    = drrip_pkg::ADDR_W;
  localparam int unsigned STRIDE_W  = drrip_pkg::STRIDE_W;
  localparam int unsigned STREAK_W  = drrip_pkg::STREAK_W;
  localparam int unsigned CHANCE_W  = drrip_pkg::CHANCE_W;
  localparam int unsigned SEL_OUT_W = drrip_pkg::SEL_OUT_W;
  localparam int unsigned THR_W     = drrip_pkg::THR_W;

  localparam logic [RRPV_WIDTH-1:0]     RRPV_SAT   = '1;
  localparam logic [SELECTOR_WIDTH-1:0] SEL_MAX    = '1;
  localparam logic [SELECTOR_WIDTH-1:0] SEL_MID    = SEL_MAX >> 1;
  localparam int unsigned               LEADER_GAP = SET_COUNT / LEADER_COUNT;

  typedef struct packed {
    logic [WAY_IN_W-1:0]  victim_way;
    logic                 stream_seen;
    logic [SEL_OUT_W-1:0] selector_value;
  } result_t;

  logic [RRPV_WIDTH-1:0]     rrpv_mem [SET_COUNT][WAY_COUNT];
  drrip_pkg::stream_entry_t  stream_mem [SET_COUNT];
  logic [SELECTOR_WIDTH-1:0] selector;
  logic [THR_W-1:0]          threshold;
  result_t                   predicted_rsp_q [$];
  result_t                   next_result;

  function automatic result_t predict_access(
    input logic                 mode,
    input logic [SET_IDX_W-1:0] set_idx,
    input logic [WAY_IN_W-1:0]  way,
    input logic [ADDR_W-1:0]    addr,
    input logic                 hit,
    input logic [CHANCE_W-1:0]  chance
  );
    result_t                  res;
    drrip_pkg::stream_entry_t ent;
    logic [STRIDE_W-1:0]      stride;
    logic [RRPV_WIDTH-1:0]    oldest;
    logic [RRPV_WIDTH-1:0]    bimodal;
    int unsigned              lead_num;
    bit                       in_leader_set;
    bit                       brrip_leader;
    bit                       found;
    int                       w;
    res = '0;
    if (mode == drrip_pkg::MODE_VICTIM) begin
      // age the set until some way reaches the maximum, then take the first such way
      oldest = '0;
      for (w = 0; w < WAY_COUNT; w++) begin
        if (rrpv_mem[set_idx][w] > oldest) oldest = rrpv_mem[set_idx][w];
      end
      if (oldest != RRPV_SAT) begin
        for (w = 0; w < WAY_COUNT; w++) begin
          rrpv_mem[set_idx][w] = rrpv_mem[set_idx][w] + (RRPV_SAT - oldest);
        end
      end
      found = 1'b0;
      for (w = 0; w < WAY_COUNT; w++) begin
        if (!found && rrpv_mem[set_idx][w] == RRPV_SAT) begin
          res.victim_way = WAY_IN_W'(w);
          found = 1'b1;
        end
      end
    end else begin
      lead_num      = set_idx / LEADER_GAP;
      in_leader_set = (set_idx % LEADER_GAP == 0) && (lead_num < LEADER_COUNT);
      brrip_leader  = lead_num >= LEADER_COUNT / 2;
      bimodal       = (chance == '0) ? RRPV_WIDTH'(1) : RRPV_SAT;

      // stride is the 21-bit two's complement difference of the 20-bit addresses
      ent    = stream_mem[set_idx];
      stride = {1'b0, addr} - {1'b0, ent.last_addr};
      if (ent.streak != '0 && stride == ent.stride && stride != '0) begin
        ent.streak      = ent.streak + 1'b1;  // wraps at 8 bits
        res.stream_seen = (ent.streak >= threshold);
      end else begin
        ent.stride = stride;
        ent.streak = STREAK_W'(1);
      end
      ent.last_addr        = addr;
      stream_mem[set_idx]  = ent;

      if (hit) begin
        rrpv_mem[set_idx][way] = '0;
      end else begin
        if (res.stream_seen)
          rrpv_mem[set_idx][way] = RRPV_SAT;
        else if (in_leader_set)
          rrpv_mem[set_idx][way] = brrip_leader ? bimodal : RRPV_WIDTH'(1);
        else
          rrpv_mem[set_idx][way] = (selector >= SEL_MID) ? RRPV_WIDTH'(1) : bimodal;

        if (in_leader_set) begin
          if (!brrip_leader) begin
            if (selector != '0) selector = selector - 1'b1;
          end else if (selector != SEL_MAX) begin
            selector = selector + 1'b1;
          end
        end
      end
    end
    res.selector_value = SEL_OUT_W'(selector);
    return res;
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (got_v !== want_v) begin
      errors_o++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SET_COUNT; s++) begin
        for (int w = 0; w < WAY_COUNT; w++) rrpv_mem[s][w] = RRPV_SAT;
        stream_mem[s] = '0;
      end
      selector  = SEL_MID;
      threshold = drrip_pkg::THR_RESET;
      predicted_rsp_q.delete();
      errors_o  = 0;
      pending_o = 0;
      checked_o = 0;
      streams_o = 0;
    end else begin
      if (cfg_we_i === 1'b1) threshold = cfg_wdata_i;

      if (req_i.valid === 1'b1 && req_i.ready === 1'b1) begin
        predicted_rsp_q.push_back(predict_access(req_i.mode, req_i.set_index, req_i.way,
                                                 req_i.paddr_lo, req_i.hit, req_i.chance));
      end

      if (rsp_i.valid === 1'b1 && rsp_i.ready === 1'b1) begin
        if (predicted_rsp_q.size() == 0) begin
          errors_o++;
          $display("%0t: unexpected result transfer, expected none, got way %0d seen %0d sel %0d",
                   $time, rsp_i.victim_way, rsp_i.stream_seen, rsp_i.selector_value);
        end else begin
          next_result = predicted_rsp_q.pop_front();
          check_field("victim_way", next_result.victim_way, rsp_i.victim_way);
          check_field("stream_seen", next_result.stream_seen, rsp_i.stream_seen);
          check_field("selector_value", next_result.selector_value, rsp_i.selector_value);
          checked_o++;
          if (next_result.stream_seen) streams_o++;
        end
      end
      pending_o = predicted_rsp_q.size();
    end
  end

endmodule

[tb/drrip_replacement_stream_bypass_tb.sv]
`timescale 1ns / 100ps
// Top-level testbench for the DRRIP replacement engine: clock, reset, request and
// threshold stimulus, result back-pressure and the verdict. Depends on drrip_pkg,
// drrip_if.sv, the engine RTL and drrip_scoreboard.
module drrip_replacement_stream_bypass_tb;

  localparam int unsigned SET_IDX_W = drrip_pkg::SET_IDX_W;
  localparam int unsigned WAY_IN_W  = drrip_pkg::WAY_IN_W;
  localparam int unsigned ADDR_W    = drrip_pkg::ADDR_W;
  localparam int unsigned CHANCE_W  = drrip_pkg::CHANCE_W;
  localparam int unsigned THR_W     = drrip_pkg::THR_W;

  localparam int unsigned LIMIT_CYCLES = 400_000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned SETS         = 2048;
  localparam int unsigned LEADER_GAP   = 32;

  typedef struct {
    logic                 mode;
    logic [SET_IDX_W-1:0] set_index;
    logic [WAY_IN_W-1:0]  way;
    logic [ADDR_W-1:0]    paddr_lo;
    logic                 hit;
    logic [CHANCE_W-1:0]  chance;
  } access_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [THR_W-1:0] cfg_wdata_i;

  bit          idle_en      = 1'b1;
  bit          hold_off_req = 1'b0;
  int unsigned cycles       = 0;
  int unsigned thr_settings = 0;
  int unsigned errors;
  int unsigned pending;
  int unsigned checked;
  int unsigned streams;

  // per-set address sequences, so that stride streams build up
  bit [ADDR_W-1:0] next_addr  [SETS];
  bit [ADDR_W-1:0] seq_stride [SETS];

  drrip_req_if req_if ();
  drrip_rsp_if rsp_if ();

  drrip_replacement_stream_bypass u_top (
    .clk_i,
    .rst_ni,
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i,
    .cfg_wdata_i
  );

  drrip_scoreboard u_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .req_i     (req_if),
    .rsp_i     (rsp_if),
    .errors_o  (errors),
    .pending_o (pending),
    .checked_o (checked),
    .streams_o (streams)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic access_t mk(input logic mode, input int unsigned set_idx,
                                 input int unsigned way, input int unsigned addr,
                                 input logic hit, input int unsigned chance);
    access_t a;
    a.mode      = mode;
    a.set_index = SET_IDX_W'(set_idx);
    a.way       = WAY_IN_W'(way);
    a.paddr_lo  = ADDR_W'(addr);
    a.hit       = hit;
    a.chance    = CHANCE_W'(chance);
    return a;
  endfunction

  // mostly continues the set's sequence; now and then restarts it with a new stride
  function automatic logic [ADDR_W-1:0] stream_addr(input logic [SET_IDX_W-1:0] s);
    logic [ADDR_W-1:0] a;
    if ($urandom_range(0, 4) == 0) begin
      seq_stride[s] = ($urandom_range(0, 3) == 0) ? ADDR_W'($urandom)
                                                   : ADDR_W'($urandom_range(1, 64));
      if ($urandom_range(0, 1) == 1) seq_stride[s] = -seq_stride[s];
      next_addr[s] = ADDR_W'($urandom);
    end
    a = next_addr[s];
    next_addr[s] = a + seq_stride[s];
    return a;
  endfunction

  function automatic logic [SET_IDX_W-1:0] pool_set();
    case ($urandom_range(0, 7))
      0:       return SET_IDX_W'(0);
      1:       return SET_IDX_W'(32);
      2:       return SET_IDX_W'(1024);
      3:       return SET_IDX_W'(2016);
      4:       return SET_IDX_W'(5);
      5:       return SET_IDX_W'(777);
      6:       return SET_IDX_W'(1500);
      default: return SET_IDX_W'(2047);
    endcase
  endfunction

  function automatic logic [SET_IDX_W-1:0] leader_set(input bit brrip);
    if ($urandom_range(0, 9) < 7) begin
      if (brrip) return ($urandom_range(0, 1) == 1) ? SET_IDX_W'(1024) : SET_IDX_W'(2016);
      return ($urandom_range(0, 1) == 1) ? SET_IDX_W'(0) : SET_IDX_W'(32);
    end
    return SET_IDX_W'(($urandom_range(0, 31) + (brrip ? 32 : 0)) * LEADER_GAP);
  endfunction

  // leader misses dominate so the selector is pushed to its limits
  function automatic access_t random_access(input bit raise_sel);
    access_t     a;
    int unsigned pick;
    pick        = $urandom_range(0, 99);
    a.mode      = drrip_pkg::MODE_UPDATE;
    a.set_index = SET_IDX_W'($urandom_range(0, SETS - 1));
    a.way       = WAY_IN_W'($urandom);
    a.paddr_lo  = ADDR_W'($urandom);
    a.hit       = 1'($urandom_range(0, 1));
    a.chance    = CHANCE_W'($urandom);
    if (pick < 75) begin
      a.set_index = leader_set(raise_sel);
      a.hit       = 1'b0;
      a.paddr_lo  = stream_addr(a.set_index);
    end else if (pick < 85) begin
      a.mode      = drrip_pkg::MODE_VICTIM;
      a.set_index = pool_set();
    end else if (pick < 93) begin
      a.set_index = pool_set();
      a.paddr_lo  = stream_addr(a.set_index);
    end else if (pick >= 97) begin
      a.mode = drrip_pkg::MODE_VICTIM;
    end
    return a;
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_access(input access_t a);
    if (idle_en && $urandom_range(0, 9) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.mode      <= a.mode;
    req_if.set_index <= a.set_index;
    req_if.way       <= a.way;
    req_if.paddr_lo  <= a.paddr_lo;
    req_if.hit       <= a.hit;
    req_if.chance    <= a.chance;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    while (pending != 0) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    thr_settings++;
  endtask

  task automatic run_segment(input int unsigned n, input bit raise_sel,
                             input logic [THR_W-1:0] thr);
    int unsigned i;
    write_threshold(thr);
    for (i = 0; i < n; i++) send_access(random_access(raise_sel));
    req_if.valid <= 1'b0;
  endtask

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    bit hold_done;
    hold_done    = 1'b0;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end else if (idle_en && $urandom_range(0, 23) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 19) - 1) @(negedge clk_i);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned k;
    req_if.valid     = 1'b0;
    req_if.mode      = drrip_pkg::MODE_VICTIM;
    req_if.set_index = '0;
    req_if.way       = '0;
    req_if.paddr_lo  = '0;
    req_if.hit       = 1'b0;
    req_if.chance    = '0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    rst_ni           = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part, threshold at its reset value
    send_access(mk(drrip_pkg::MODE_VICTIM, 0, 15, 'hFFFFF, 1'b1, 31)); // unused fields high
    send_access(mk(drrip_pkg::MODE_UPDATE, 0, 15, 'hFFFFF, 1'b0, 0));  // SRRIP leader miss
    send_access(mk(drrip_pkg::MODE_UPDATE, 0, 0, 0, 1'b1, 31));        // hit
    send_access(mk(drrip_pkg::MODE_VICTIM, 0, 0, 0, 1'b0, 0));
    send_access(mk(drrip_pkg::MODE_UPDATE, 1024, 3, 'h12345, 1'b0, 0)); // BRRIP leader, near
    send_access(mk(drrip_pkg::MODE_UPDATE, 1024, 4, 'h12346, 1'b0, 31));
    send_access(mk(drrip_pkg::MODE_UPDATE, 2047, 9, 'hABCDE, 1'b0, 31)); // follower
    send_access(mk(drrip_pkg::MODE_VICTIM, 2047, 0, 0, 1'b0, 0));
    for (k = 1; k <= 4; k++)
      send_access(mk(drrip_pkg::MODE_UPDATE, 5, k, k * 'h10, 1'b0, 7));
    send_access(mk(drrip_pkg::MODE_UPDATE, 5, 0, 'h50, 1'b1, 7));        // hit while streaming
    send_access(mk(drrip_pkg::MODE_VICTIM, 5, 0, 0, 1'b0, 0));
    send_access(mk(drrip_pkg::MODE_UPDATE, 2016, 6, 'h00400, 1'b0, 1)); // last BRRIP leader
    send_access(mk(drrip_pkg::MODE_UPDATE, 32, 7, 'h00800, 1'b0, 0));
    // negative stride, then a wrap through zero that breaks it
    for (k = 0; k < 4; k++)
      send_access(mk(drrip_pkg::MODE_UPDATE, 777, 10 + k, 7 - 2 * k, 1'b0, 2));
    send_access(mk(drrip_pkg::MODE_UPDATE, 777, 14, 'hFFFFF, 1'b0, 2));
    // repeated address: zero stride never streams
    for (k = 0; k < 3; k++)
      send_access(mk(drrip_pkg::MODE_UPDATE, 1500, k, 'h55555, k[0], 3));
    req_if.valid <= 1'b0;

    // random part: selector pushed up, then down, across several thresholds
    hold_off_req = 1'b1;
    run_segment(375, 1'b1, THR_W'(1));
    run_segment(375, 1'b1, THR_W'($urandom_range(2, 6)));
    run_segment(400, 1'b0, THR_W'(0));
    run_segment(350, 1'b0, THR_W'(255));
    run_segment(450, 1'b0, THR_W'($urandom_range(2, 6)));
    idle_en = 1'b0;
    for (k = 0; k < 250; k++) send_access(random_access(1'b0));
    req_if.valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Checked %0d result transfers under %0d threshold writes; %0d saw streaming.",
             checked, thr_settings, streams);
    $display("Selector driven by leader misses in both directions, with one long output stall.");
    if (errors == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

[files.f]
rtl/drrip_pkg.sv
rtl/drrip_if.sv
rtl/drrip_ram.sv
rtl/drrip_replacement_stream_bypass.sv
rtl/drrip_checker.sv
tb/drrip_checker.sv
tb/drrip_replacement_stream_bypass_tb.sv
